/* design/assert_macros.svh */
// assertion helpers for the timer table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define CHK_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

/* design/mstt_pkg.sv */
// ----------------------------------------------------------------------------
// mstt_pkg
// types, codes and helpers shared by the timer table
// ----------------------------------------------------------------------------
package mstt_pkg;
  localparam int SLOTS = 16;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_CREATE = 3'd1;
  localparam logic [2:0] REQ_PAUSE  = 3'd2;
  localparam logic [2:0] REQ_RESUME = 3'd3;
  localparam logic [2:0] REQ_TOGGLE = 3'd4;
  localparam logic [2:0] REQ_CLEAR  = 3'd5;
  localparam logic [2:0] REQ_STATUS = 3'd6;

  localparam logic [2:0] K_TIMEOUT  = 3'd0;
  localparam logic [2:0] K_INTERVAL = 3'd1;
  localparam logic [2:0] K_SEC      = 3'd2;
  localparam logic [2:0] K_MS       = 3'd3;
  localparam logic [2:0] K_MIN      = 3'd4;

  localparam logic [2:0] ST_INVALID   = 3'd0;
  localparam logic [2:0] ST_RUNNING   = 3'd1;
  localparam logic [2:0] ST_PAUSED    = 3'd2;
  localparam logic [2:0] ST_STOPPED   = 3'd3;
  localparam logic [2:0] ST_COMPLETED = 3'd4;

  // reciprocals for the rounding divide: x/1000 = (x*RCP_SEC)>>41,
  // x/60000 = ((x>>5)*RCP_MIN)>>38, exact for every 32-bit x
  localparam logic [31:0] RCP_SEC = 32'd2199023256;
  localparam logic [31:0] RCP_MIN = 32'd146601551;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  timer_kind;
    logic [31:0] timer_id;
    logic [31:0] duration_ms;
    logic [31:0] now_ms;
    logic        match_any_kind;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        ok;
    logic [31:0] result_id;
    logic [2:0]  status_code;
    logic [2:0]  fired_kind;
    logic [31:0] remaining;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        active;
    logic [2:0]  kind;
    logic [31:0] ident;
    logic        paused;
    logic [31:0] deadline;
    logic [31:0] period;
    logic [31:0] mark;
  } slot_t;

  // command for the cell at the head of the ring; no module in the project uses it
  typedef struct packed {
    logic        en;
    logic        load;
    slot_t       val;
  } head_ctl_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV, S_DONE} state_t;
endpackage

/* design/multi_slot_timer_table.sv */
// ----------------------------------------------------------------------------
// multi_slot_timer_table
// timer slot table held in a rotating ring of slot cells
// ----------------------------------------------------------------------------
// channel | ports                      | handshake
// request | start, busy, in_item       | taken when start && !busy
// result  | out_strobe, out_item       | one cycle per result, no stall
// config  | cfg_valid, cfg_ready, cfg_data | taken when valid && ready
//
// every request rotates the ring of SLOTS cells once: one shift per slot,
// one end check and the closing reply, with busy high throughout; a new
// request is taken only once the last one is through, and each seconds or
// minutes countdown fire stalls the scan for the rounding divide.
// reset is synchronous; next id goes to one and all slots go free.
// busy stays high from acceptance until the closing reply is strobed.
module multi_slot_timer_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mstt_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output mstt_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import mstt_pkg::*;

  state_t    st_r, st_nxt;
  in_item_t  req_r;
  logic      en_r;
  logic [31:0] nid_r, nid_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic      found_r, found_nxt;   // create placed, or lookup matched
  logic      ok_r, ok_nxt;
  logic [2:0] sc_r, sc_nxt;
  out_item_t ev_r, ev_nxt;         // fire event waiting on the divider
  logic      fire, need_div;       // fire event at the head this cycle

  slot_t ring [SLOTS];
  slot_t head_new;
  logic  shift;

  // ring: cell i takes from cell i+1, the last cell takes the edited head
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    slot_t din;
    if (g == SLOTS - 1) begin : g_tail
      assign din = head_new;
    end else begin : g_mid
      assign din = ring[g+1];
    end
    mstt_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d_in(din), .q(ring[g]));
  end

  slot_t h;
  assign h = ring[0];

  // divider for countdown rounding
  logic        dv_start, dv_done, dv_min;
  logic [31:0] dv_dend;
  logic [31:0] dv_q;
  mstt_div u_div (.clk(clk), .rst_n(rst_n), .start(dv_start), .min_sel(dv_min),
                  .dividend(dv_dend), .done(dv_done), .quotient(dv_q));

  assign cfg_ready = (st_r == S_IDLE);
  assign busy = (st_r != S_IDLE);

  // per-slot evaluation at the head
  logic [31:0] el, unit, left;
  logic        due, match;
  always_comb begin
    el = req_r.now_ms - h.mark;
    case (h.kind)
      K_SEC:   unit = 32'd1000;
      K_MS:    unit = 32'd1;
      default: unit = 32'd60000;
    endcase
    left = h.deadline - req_r.now_ms;
    if (left[31]) left = '0;
    case (h.kind)
      K_TIMEOUT:  due = el >= (h.deadline - h.mark);
      K_INTERVAL: due = el >= h.period;
      default:    due = el >= unit;
    endcase
    match = h.active && (h.ident == req_r.timer_id) &&
            ((req_r.match_any_kind && req_r.req_type == REQ_STATUS) ||
             h.kind == req_r.timer_kind);
  end

  // next state and slot edits
  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; found_nxt = found_r; ok_nxt = ok_r;
    sc_nxt = sc_r; nid_nxt = nid_r; ev_nxt = ev_r;
    head_new = h; shift = 1'b0; fire = 1'b0; need_div = 1'b0;
    dv_start = 1'b0; dv_dend = '0; dv_min = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          st_nxt = S_SCAN; cnt_nxt = '0; found_nxt = 1'b0; ok_nxt = 1'b0;
          sc_nxt = ST_INVALID;
        end
      end
      S_SCAN: begin
        if (cnt_r == CW'(SLOTS)) begin
          st_nxt = S_DONE;
        end else begin
          shift = 1'b1; cnt_nxt = cnt_r + 1'b1;
          if (en_r) begin
            case (req_r.req_type)
              REQ_TICK: begin
                if (h.active && !h.paused && due) begin
                  fire = 1'b1;
                  ev_nxt = '0;
                  ev_nxt.result_kind = 1'b1; ev_nxt.ok = 1'b1;
                  ev_nxt.result_id = h.ident;
                  ev_nxt.fired_kind = h.kind;
                  if (h.kind == K_TIMEOUT) begin
                    ev_nxt.fired_kind = K_TIMEOUT;
                    ev_nxt.status_code = ST_COMPLETED;
                    head_new.active = 1'b0;
                  end else begin
                    ev_nxt.status_code = ST_RUNNING;
                    head_new.mark = req_r.now_ms;
                    if (h.kind != K_INTERVAL) begin
                      if (left == '0) begin
                        ev_nxt.status_code = ST_COMPLETED;
                        head_new.active = 1'b0;
                      end
                      ev_nxt.remaining = left;
                    end
                  end
                  need_div = !((h.kind == K_TIMEOUT) || (h.kind == K_INTERVAL) ||
                               (h.kind == K_MS));
                  if (need_div) begin
                    // seconds or minutes: round up through the divider
                    dv_start = 1'b1;
                    dv_dend = left + ((h.kind == K_SEC) ? 32'd999 : 32'd59999);
                    dv_min = (h.kind != K_SEC);
                    st_nxt = S_DIV;
                  end
                end
              end
              REQ_CREATE: begin
                if (!found_r && !h.active && req_r.timer_kind <= K_MIN) begin
                  found_nxt = 1'b1; ok_nxt = 1'b1; sc_nxt = ST_RUNNING;
                  head_new.active = 1'b1; head_new.kind = req_r.timer_kind;
                  head_new.ident = nid_r; head_new.paused = 1'b0;
                  head_new.mark = req_r.now_ms;
                  head_new.deadline = req_r.now_ms + req_r.duration_ms;
                  head_new.period = req_r.duration_ms;
                  nid_nxt = (nid_r == 32'hFFFF_FFFF) ? 32'd1 : nid_r + 32'd1;
                end
              end
              REQ_PAUSE, REQ_RESUME, REQ_TOGGLE, REQ_CLEAR, REQ_STATUS: begin
                if (!found_r && match) begin
                  found_nxt = 1'b1;
                  sc_nxt = h.paused ? ST_PAUSED : ST_RUNNING;
                  case (req_r.req_type)
                    REQ_PAUSE: if (!h.paused) begin
                      head_new.paused = 1'b1; ok_nxt = 1'b1; sc_nxt = ST_PAUSED;
                    end
                    REQ_CLEAR: begin
                      head_new.active = 1'b0; ok_nxt = 1'b1; sc_nxt = ST_STOPPED;
                    end
                    REQ_STATUS: ok_nxt = 1'b1;
                    default: begin
                      if (h.paused) begin
                        head_new.paused = 1'b0; ok_nxt = 1'b1; sc_nxt = ST_RUNNING;
                        if (h.kind != K_TIMEOUT) head_new.mark = req_r.now_ms;
                      end else if (req_r.req_type == REQ_TOGGLE) begin
                        head_new.paused = 1'b1; ok_nxt = 1'b1; sc_nxt = ST_PAUSED;
                      end
                    end
                  endcase
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_DIV: begin
        if (dv_done) st_nxt = S_SCAN;
      end
      S_DONE: begin
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // result outputs
  always_comb begin
    out_strobe = 1'b0; out_item = '0;
    case (st_r)
      S_SCAN: begin
        if (fire && !need_div) begin
          out_strobe = 1'b1; out_item = ev_nxt;
        end
      end
      S_DIV: begin
        if (dv_done) begin
          out_strobe = 1'b1; out_item = ev_r; out_item.remaining = dv_q;
        end
      end
      S_DONE: begin
        out_strobe = 1'b1; out_item.last = 1'b1;
        if (req_r.req_type == REQ_TICK) begin
          out_item.ok = en_r;
        end else begin
          out_item.ok = ok_r; out_item.status_code = sc_r;
          // id handed out is the one before the counter, across the wrap
          if (req_r.req_type == REQ_CREATE && ok_r)
            out_item.result_id = (nid_r == 32'd1) ? 32'hFFFF_FFFF : nid_r - 32'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; en_r <= 1'b1; nid_r <= 32'd1;
    end else begin
      st_r <= st_nxt; nid_r <= nid_nxt;
      if (cfg_valid && cfg_ready) en_r <= cfg_data;
    end
    cnt_r <= cnt_nxt; found_r <= found_nxt; ok_r <= ok_nxt; sc_r <= sc_nxt;
    ev_r <= ev_nxt;
    if (st_r == S_IDLE && start) req_r <= in_item;
  end

  `include "assert_macros.svh"
  `CHK_IMP(a_strobe_busy, out_strobe, busy, "result outside a request")
  `CHK_NXT(a_last_idle, out_strobe && out_item.last, !busy, "busy after last result")
  `CHK_IMP(a_cfg_idle, cfg_ready, !busy, "config taken while busy")
endmodule

/* design/mstt_cell.sv */
// ----------------------------------------------------------------------------
// mstt_cell
// one slot register of the rotating ring
// ----------------------------------------------------------------------------
module mstt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  mstt_pkg::slot_t d_in,
  output mstt_pkg::slot_t q
);
  import mstt_pkg::*;
  slot_t q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.active <= 1'b0;
    end else if (shift) begin
      q_r <= d_in;
    end
  end
  assign q = q_r;
endmodule

/* design/mstt_div.sv */
// ----------------------------------------------------------------------------
// mstt_div
// divide by 1000 or 60000 through a reciprocal multiply; the operand, then the product, are registered
// ----------------------------------------------------------------------------
module mstt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        min_sel,
  input  logic [31:0] dividend,
  output logic        done,
  output logic [31:0] quotient
);
  import mstt_pkg::*;
  logic [31:0] a_r, a_nxt;
  logic        sel_r, sel_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [63:0] p_r;
  logic [31:0] m;
  always_comb begin
    a_nxt = a_r; sel_nxt = sel_r; ph_nxt = ph_r;
    if (start) begin
      // minutes: drop the factor of 32 first
      a_nxt = min_sel ? {5'd0, dividend[31:5]} : dividend;
      sel_nxt = min_sel; ph_nxt = 2'd1;
    end else if (ph_r == 2'd1) begin
      ph_nxt = 2'd2;
    end else if (ph_r == 2'd2) begin
      ph_nxt = 2'd0;
    end
  end
  assign m = sel_r ? RCP_MIN : RCP_SEC;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 2'd0;
    end else begin
      ph_r <= ph_nxt;
    end
    a_r <= a_nxt; sel_r <= sel_nxt;
    p_r <= {32'd0, a_r} * {32'd0, m};
  end
  assign done = (ph_r == 2'd2);
  assign quotient = sel_r ? {6'd0, p_r[63:38]} : {9'd0, p_r[63:41]};
endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the timer slot table: directed table, a disabled pass, then random
// requests, every reply and fire event compared against a behavioural model
// ----------------------------------------------------------------------------
module tb;
  import mstt_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  multi_slot_timer_table u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // behavioural copy of the table
  slot_t       tbl [SLOTS];
  logic [31:0] id_counter;
  logic        enabled;

  out_item_t pending_results[$];
  int        mismatch_count;
  int        idle_cycles;
  logic      no_gaps;

  // per-kind fire step in ms
  function automatic logic [31:0] unit_of(logic [2:0] k);
    if (k == K_SEC) return 32'd1000;
    if (k == K_MS) return 32'd1;
    return 32'd60000;
  endfunction

  function automatic out_item_t mk(logic rk, logic okv, logic [31:0] id,
                                   logic [2:0] st, logic [2:0] fk,
                                   logic [31:0] rem, logic lst);
    out_item_t r;
    r.result_kind = rk; r.ok = okv; r.result_id = id; r.status_code = st;
    r.fired_kind = fk; r.remaining = rem; r.last = lst;
    return r;
  endfunction

  // works out the results of one request and updates the table
  task automatic predict_request(in_item_t q);
    int          s;
    logic [31:0] left, rem;
    logic        okv;
    logic [2:0]  st;
    logic        paused;
    logic        resume;
    s = -1; okv = 1'b0; st = ST_INVALID; resume = 1'b0;
    if (q.req_type == REQ_TICK) begin
      if (!enabled) begin
        pending_results.push_back(mk(1'b0, 1'b0, 32'd0, ST_INVALID, 3'd0, 32'd0, 1'b1));
        return;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (!tbl[i].active || tbl[i].paused) continue;
        if (tbl[i].kind == K_TIMEOUT) begin
          if (q.now_ms - tbl[i].mark >= tbl[i].deadline - tbl[i].mark) begin
            pending_results.push_back(mk(1'b1, 1'b1, tbl[i].ident, ST_COMPLETED, K_TIMEOUT,
                                         32'd0, 1'b0));
            tbl[i].active = 1'b0;
          end
        end else if (tbl[i].kind == K_INTERVAL) begin
          if (q.now_ms - tbl[i].mark >= tbl[i].period) begin
            tbl[i].mark = q.now_ms;
            pending_results.push_back(mk(1'b1, 1'b1, tbl[i].ident, ST_RUNNING, K_INTERVAL,
                                         32'd0, 1'b0));
          end
        end else if (q.now_ms - tbl[i].mark >= unit_of(tbl[i].kind)) begin
          tbl[i].mark = q.now_ms;
          left = tbl[i].deadline - q.now_ms;
          if (left[31]) left = 0;
          if (tbl[i].kind == K_SEC) rem = 32'((64'(left) + 999) / 1000);
          else if (tbl[i].kind == K_MS) rem = left;
          else rem = 32'((64'(left) + 59999) / 60000);
          if (left == 0) begin
            pending_results.push_back(mk(1'b1, 1'b1, tbl[i].ident, ST_COMPLETED,
                                         tbl[i].kind, rem, 1'b0));
            tbl[i].active = 1'b0;
          end else begin
            pending_results.push_back(mk(1'b1, 1'b1, tbl[i].ident, ST_RUNNING,
                                         tbl[i].kind, rem, 1'b0));
          end
        end
      end
      pending_results.push_back(mk(1'b0, 1'b1, 32'd0, ST_INVALID, 3'd0, 32'd0, 1'b1));
      return;
    end
    if (q.req_type == REQ_CREATE) begin
      if (enabled && q.timer_kind <= K_MIN) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl[i].active) begin
            tbl[i].active = 1'b1; tbl[i].kind = q.timer_kind; tbl[i].ident = id_counter;
            tbl[i].paused = 1'b0; tbl[i].mark = q.now_ms;
            tbl[i].deadline = q.now_ms + q.duration_ms; tbl[i].period = q.duration_ms;
            pending_results.push_back(mk(1'b0, 1'b1, id_counter, ST_RUNNING, 3'd0, 32'd0,
                                         1'b1));
            id_counter = id_counter + 1;
            if (id_counter == 0) id_counter = 1;
            return;
          end
        end
      end
      pending_results.push_back(mk(1'b0, 1'b0, 32'd0, ST_INVALID, 3'd0, 32'd0, 1'b1));
      return;
    end
    if (!enabled || q.req_type > REQ_STATUS) begin
      pending_results.push_back(mk(1'b0, 1'b0, 32'd0, ST_INVALID, 3'd0, 32'd0, 1'b1));
      return;
    end
    for (int i = SLOTS - 1; i >= 0; i--)
      if (tbl[i].active && tbl[i].ident == q.timer_id &&
          ((q.req_type == REQ_STATUS && q.match_any_kind) || tbl[i].kind == q.timer_kind))
        s = i;
    if (s >= 0) begin
      paused = tbl[s].paused;
      st = paused ? ST_PAUSED : ST_RUNNING;
      case (q.req_type)
        REQ_PAUSE: if (!paused) begin
          tbl[s].paused = 1'b1; okv = 1'b1; st = ST_PAUSED;
        end
        REQ_RESUME: resume = paused;
        REQ_TOGGLE: if (paused) resume = 1'b1;
          else begin
            tbl[s].paused = 1'b1; okv = 1'b1; st = ST_PAUSED;
          end
        REQ_CLEAR: begin
          tbl[s].active = 1'b0; okv = 1'b1; st = ST_STOPPED;
        end
        default: okv = 1'b1;
      endcase
      if (resume) begin
        tbl[s].paused = 1'b0;
        if (tbl[s].kind != K_TIMEOUT) tbl[s].mark = q.now_ms;
        okv = 1'b1; st = ST_RUNNING;
      end
    end
    pending_results.push_back(mk(1'b0, okv, 32'd0, st, 3'd0, 32'd0, 1'b1));
  endtask

  // result monitor, sampled at the edge that ends the strobe cycle
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = pending_results.pop_front();
        if (out_item !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("expected %p got %p", want, out_item);
        end
      end
    end
  end

  // watchdog: cycles with no request or config write taken and no result seen
  always @(posedge clk) begin
    if (!rst_n || out_strobe || (start && !busy) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one request through the handshake, at times with a random idle gap before it;
  // start stays high after acceptance until the next request or a pause
  task automatic send_request(in_item_t q);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      do @(posedge clk); while (busy);
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= q;
    do @(posedge clk); while (busy);
    predict_request(q);
  endtask

  // write the enable register once the table has drained
  task automatic write_enable(logic v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    enabled = v;
    cfg_valid <= 1'b0;
  endtask

  // recent ids for lookups, so most requests hit a live timer
  function automatic logic [31:0] pick_id();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return id_counter - 32'($urandom_range(1, 20));
  endfunction

  // directed rows: request, kind, id, duration, now, any
  in_item_t    directed [$];
  logic [31:0] clock_ms;
  in_item_t    q;

  function automatic in_item_t row(logic [2:0] r, logic [2:0] k, logic [31:0] id,
                                   logic [31:0] d, logic [31:0] n, logic a);
    in_item_t x;
    x.req_type = r; x.timer_kind = k; x.timer_id = id; x.duration_ms = d;
    x.now_ms = n; x.match_any_kind = a;
    return x;
  endfunction

  initial begin
    rst_n = 1'b0; start = 1'b0; in_item = '0;
    cfg_valid = 1'b0; cfg_data = 1'b0;
    mismatch_count = 0; idle_cycles = 0; no_gaps = 1'b0;
    for (int i = 0; i < SLOTS; i++) tbl[i] = '0;
    id_counter = 1; enabled = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, every request type, wrap of time, unknown kind and request
    directed.push_back(row(REQ_TICK,   K_TIMEOUT,  0, 0, 32'hFFFF_FFFF, 1'b0));
    directed.push_back(row(REQ_STATUS, K_TIMEOUT,  1, 0, 0, 1'b1));
    directed.push_back(row(REQ_CREATE, K_TIMEOUT,  0, 0, 0, 1'b0));
    directed.push_back(row(REQ_CREATE, K_INTERVAL, 0, 10, 32'hFFFF_FFF0, 1'b0));
    directed.push_back(row(REQ_CREATE, K_SEC,      0, 2500, 0, 1'b0));
    directed.push_back(row(REQ_CREATE, K_MS,       0, 3, 0, 1'b0));
    directed.push_back(row(REQ_CREATE, K_MIN,      0, 32'hFFFF_FFFF, 0, 1'b0));
    directed.push_back(row(REQ_CREATE, 3'd7,       0, 5, 0, 1'b0));
    directed.push_back(row(REQ_CREATE, 3'd5,       0, 5, 0, 1'b0));
    directed.push_back(row(REQ_TICK,   K_TIMEOUT,  0, 0, 5, 1'b0));
    directed.push_back(row(REQ_PAUSE,  K_SEC,      3, 0, 5, 1'b0));
    directed.push_back(row(REQ_PAUSE,  K_SEC,      3, 0, 5, 1'b0));
    directed.push_back(row(REQ_RESUME, K_SEC,      3, 0, 6, 1'b0));
    directed.push_back(row(REQ_RESUME, K_SEC,      3, 0, 6, 1'b0));
    directed.push_back(row(REQ_TOGGLE, K_MS,       4, 0, 7, 1'b0));
    directed.push_back(row(REQ_TOGGLE, K_MS,       4, 0, 8, 1'b0));
    directed.push_back(row(REQ_STATUS, K_TIMEOUT,  5, 0, 8, 1'b1));
    directed.push_back(row(REQ_STATUS, K_TIMEOUT,  5, 0, 8, 1'b0));
    directed.push_back(row(REQ_TICK,   K_TIMEOUT,  0, 0, 3000, 1'b0));
    directed.push_back(row(REQ_CLEAR,  K_INTERVAL, 2, 0, 3000, 1'b0));
    directed.push_back(row(REQ_CLEAR,  K_INTERVAL, 2, 0, 3000, 1'b0));
    directed.push_back(row(3'd7,       K_TIMEOUT,  32'hFFFF_FFFF, 0, 0, 1'b1));
    directed.push_back(row(REQ_TICK,   K_TIMEOUT,  0, 0, 32'h8000_0000, 1'b0));
    foreach (directed[i]) send_request(directed[i]);

    // disabled block: everything fails
    write_enable(1'b0);
    send_request(row(REQ_CREATE, K_MS, 0, 1, 0, 1'b0));
    send_request(row(REQ_TICK, K_TIMEOUT, 0, 0, 32'h9000_0000, 1'b0));
    send_request(row(REQ_STATUS, K_TIMEOUT, 5, 0, 0, 1'b1));
    write_enable(1'b1);

    // random traffic with a moving clock, mostly creates, ticks and lookups
    clock_ms = 32'h8000_0000;
    for (int n = 0; n < 400; n++) begin
      if (n == 200) write_enable(1'b0);
      if (n == 215) write_enable(1'b1);
      if (n > 340) no_gaps = 1'b1;
      q.timer_kind     = 3'($urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                                                      : $urandom_range(0, 4));
      q.match_any_kind = 1'($urandom_range(0, 1));
      q.timer_id       = pick_id();
      case ($urandom_range(0, 4))
        0: q.duration_ms = $urandom();
        1: q.duration_ms = $urandom_range(0, 5);
        default: q.duration_ms = $urandom_range(0, 200000);
      endcase
      clock_ms   = clock_ms + ($urandom_range(0, 7) == 0 ? $urandom()
                                                         : $urandom_range(0, 30000));
      q.now_ms   = clock_ms;
      case ($urandom_range(0, 11))
        0, 1, 2, 3: q.req_type = REQ_TICK;
        4, 5, 6:    q.req_type = REQ_CREATE;
        7:          q.req_type = REQ_PAUSE;
        8:          q.req_type = REQ_RESUME;
        9:          q.req_type = REQ_TOGGLE;
        10:         q.req_type = $urandom_range(0, 1) ? REQ_CLEAR : 3'd7;
        default:    q.req_type = REQ_STATUS;
      endcase
      send_request(q);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
